// ===== rtl/http_date_to_epoch_parser_core_macros.svh =====
// assertion macros shared by the http date parser rtl
`ifndef HTTP_DATE_TO_EPOCH_PARSER_CORE_MACROS_SVH
`define HTTP_DATE_TO_EPOCH_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define HDEP_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define HDEP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define HDEP_ASSERT_NOW(label, pre, post)
`define HDEP_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== rtl/hdep_pkg.sv =====
// types, tables and per-character parse functions of the http date parser
`timescale 1ns / 1ps
package hdep_pkg;

    localparam int unsigned NameCount = 26;
    localparam int unsigned MonthBase = 14;
    localparam int unsigned FeedSteps = 4;
    localparam logic [25:0] AllNames = 26'h3FF_FFFF;
    localparam logic [13:0] NumLimit = 14'd9999;
    localparam logic [7:0] ChZero = 8'h00;

    typedef enum logic [9:0] {
        PH_WDAY    = 10'b00_0000_0001,
        PH_WORD2   = 10'b00_0000_0010,
        PH_MDAY    = 10'b00_0000_0100,
        PH_HOUR    = 10'b00_0000_1000,
        PH_MIN     = 10'b00_0001_0000,
        PH_SEC     = 10'b00_0010_0000,
        PH_YEAR    = 10'b00_0100_0000,
        PH_MONWORD = 10'b00_1000_0000,
        PH_ZONE    = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } hdep_phase_t;

    typedef struct packed {
        hdep_phase_t phase;
        logic        long_form;
        logic [25:0] flags;
        logic [3:0]  pos;
        logic        in_token;
        logic [13:0] num;
        logic [3:0]  mon;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
        logic [13:0] yrs;
        logic        failed;
    } hdep_state_t;

    typedef struct packed {
        hdep_state_t st;
        logic        cont;
    } hdep_step_t;

    // request snapshot handed from scanner to finisher
    typedef struct packed {
        hdep_state_t st;
        logic        needs_zero;
    } hdep_snap_t;

    // parsed fields handed to the epoch stages
    typedef struct packed {
        logic        ok;
        logic [13:0] yrs;
        logic [3:0]  mon;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } hdep_fields_t;

    function automatic hdep_state_t reset_state();
        hdep_state_t s;
        s = '0;
        s.phase = PH_WDAY;
        s.flags = AllNames;
        return s;
    endfunction

    // names padded with spaces to ten characters
    function automatic logic [79:0] name_str(input int unsigned idx);
        logic [79:0] s;
        unique case (idx)
            0:  s = "sun       ";
            1:  s = "mon       ";
            2:  s = "tue       ";
            3:  s = "wed       ";
            4:  s = "thu       ";
            5:  s = "fri       ";
            6:  s = "sat       ";
            7:  s = "sunday    ";
            8:  s = "monday    ";
            9:  s = "tuesday   ";
            10: s = "wednesday ";
            11: s = "thursday  ";
            12: s = "friday    ";
            13: s = "saturday  ";
            14: s = "jan       ";
            15: s = "feb       ";
            16: s = "mar       ";
            17: s = "apr       ";
            18: s = "may       ";
            19: s = "jun       ";
            20: s = "jul       ";
            21: s = "aug       ";
            22: s = "sep       ";
            23: s = "oct       ";
            24: s = "nov       ";
            default: s = "dec       ";
        endcase
        return s;
    endfunction

    function automatic logic [3:0] name_len(input int unsigned idx);
        logic [3:0] n;
        unique case (idx)
            7, 8, 12: n = 4'd6;
            9:        n = 4'd7;
            10:       n = 4'd9;
            11, 13:   n = 4'd8;
            default:  n = 4'd3;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] name_char(input int unsigned idx, input logic [3:0] pos);
        logic [79:0] s;
        logic [7:0]  ch;
        int unsigned sh;
        s = name_str(idx);
        ch = ChZero;
        if (pos < 4'd10) begin
            sh = (32'd9 - 32'(pos)) * 32'd8;
            ch = s[sh +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] gmt_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "g";
            4'd1:    ch = "m";
            default: ch = "t";
        endcase
        return ch;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_phase(input hdep_phase_t p);
        return p == PH_WDAY || p == PH_WORD2 || p == PH_MONWORD || p == PH_ZONE;
    endfunction

    // one letter of a word against every candidate name
    function automatic hdep_state_t word_letter(input hdep_state_t s_in, input logic [7:0] c);
        hdep_state_t s;
        logic [7:0]  lc;
        s = s_in;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (s.phase == PH_ZONE) begin
            if (s.pos < 4'd3 && gmt_char(s.pos) != lc)
                s.flags[0] = 1'b0;
        end
        else begin
            for (int unsigned i = 0; i < NameCount; i++) begin
                if (name_char(i, s.pos) != lc)
                    s.flags[i] = 1'b0;
            end
        end
        if (s.pos != 4'd15)
            s.pos = s.pos + 4'd1;
        return s;
    endfunction

    // close a word and act on what it matched
    function automatic hdep_state_t word_end(input hdep_state_t s_in);
        hdep_state_t s;
        logic        wday_hit;
        logic        mon_hit;
        logic [3:0]  mon_idx;
        s = s_in;
        wday_hit = 1'b0;
        mon_hit = 1'b0;
        mon_idx = 4'd0;
        for (int unsigned i = 0; i < MonthBase; i++) begin
            if (s.flags[i] && s.pos == name_len(i))
                wday_hit = 1'b1;
        end
        for (int unsigned i = MonthBase; i < NameCount; i++) begin
            if (s.flags[i] && s.pos == 4'd3) begin
                mon_hit = 1'b1;
                mon_idx = 4'(i - MonthBase);
            end
        end
        unique case (s.phase)
            PH_WDAY: begin
                if (!wday_hit)
                    s.failed = 1'b1;
                else
                    s.phase = PH_WORD2;
            end
            PH_WORD2: begin
                s.long_form = mon_hit;
                if (mon_hit)
                    s.mon = mon_idx;
                s.phase = PH_MDAY;
            end
            PH_MONWORD: begin
                if (!mon_hit)
                    s.failed = 1'b1;
                else begin
                    s.mon = mon_idx;
                    s.phase = PH_YEAR;
                end
            end
            default: begin
                if (s.flags[0] && s.pos >= 4'd3)
                    s.phase = PH_DONE;
                else
                    s.failed = 1'b1;
            end
        endcase
        s.in_token = 1'b0;
        s.pos = 4'd0;
        s.flags = AllNames;
        return s;
    endfunction

    // close a number and check its range for the current element
    function automatic hdep_state_t number_end(input hdep_state_t s_in);
        hdep_state_t s;
        logic [13:0] n;
        s = s_in;
        n = s.num;
        unique case (s.phase)
            PH_MDAY: begin
                if (n < 14'd1 || n > 14'd31)
                    s.failed = 1'b1;
                else begin
                    s.mday = n[4:0];
                    s.phase = s.long_form ? PH_HOUR : PH_MONWORD;
                end
            end
            PH_HOUR: begin
                if (n >= 14'd24)
                    s.failed = 1'b1;
                else begin
                    s.hour = n[4:0];
                    s.phase = PH_MIN;
                end
            end
            PH_MIN: begin
                if (n >= 14'd60)
                    s.failed = 1'b1;
                else begin
                    s.minute = n[5:0];
                    s.phase = PH_SEC;
                end
            end
            PH_SEC: begin
                if (n >= 14'd60)
                    s.failed = 1'b1;
                else begin
                    s.sec = n[5:0];
                    s.phase = s.long_form ? PH_YEAR : PH_ZONE;
                end
            end
            default: begin
                if (n < 14'd70 || (n > 14'd99 && n < 14'd1970))
                    s.failed = 1'b1;
                else begin
                    s.yrs = (n >= 14'd1970) ? n - 14'd1900 : n;
                    s.phase = s.long_form ? PH_DONE : PH_HOUR;
                end
            end
        endcase
        s.in_token = 1'b0;
        s.num = 14'd0;
        return s;
    endfunction

    // one pass of the element scanner; cont asks for another pass on the same char
    function automatic hdep_step_t feed_step(input hdep_state_t s_in, input logic [7:0] c);
        hdep_step_t  r;
        logic [17:0] acc;
        r.st = s_in;
        r.cont = 1'b0;
        if (is_word_phase(s_in.phase)) begin
            if (is_alpha(c)) begin
                if (!r.st.in_token) begin
                    r.st.in_token = 1'b1;
                    r.st.pos = 4'd0;
                    r.st.flags = AllNames;
                end
                r.st = word_letter(r.st, c);
            end
            else if (r.st.in_token || is_digit(c) || c == ChZero) begin
                r.st = word_end(r.st);
                r.cont = 1'b1;
            end
        end
        else begin
            if (is_digit(c)) begin
                if (!r.st.in_token) begin
                    r.st.in_token = 1'b1;
                    r.st.num = 14'd0;
                end
                acc = {4'd0, r.st.num} * 18'd10 + {14'd0, c[3:0]};
                r.st.num = (acc > {4'd0, NumLimit}) ? NumLimit : acc[13:0];
            end
            else if (r.st.in_token) begin
                r.st = number_end(r.st);
                r.cont = 1'b1;
            end
            else if (c == ChZero) begin
                r.st.failed = 1'b1;
            end
        end
        return r;
    endfunction

    // a character ends at most a few elements before it is consumed
    function automatic hdep_state_t feed(input hdep_state_t s_in, input logic [7:0] c);
        hdep_state_t s;
        hdep_step_t  r;
        logic        go;
        s = s_in;
        go = 1'b1;
        for (int unsigned k = 0; k < FeedSteps; k++) begin
            if (go && !s.failed && s.phase != PH_DONE) begin
                r = feed_step(s, c);
                s = r.st;
                go = r.cont;
            end
            else begin
                go = 1'b0;
            end
        end
        return s;
    endfunction

    function automatic logic [21:0] cum_days(input logic [3:0] mon);
        logic [21:0] d;
        unique case (mon)
            4'd0:    d = 22'd0;
            4'd1:    d = 22'd31;
            4'd2:    d = 22'd59;
            4'd3:    d = 22'd90;
            4'd4:    d = 22'd120;
            4'd5:    d = 22'd151;
            4'd6:    d = 22'd181;
            4'd7:    d = 22'd212;
            4'd8:    d = 22'd243;
            4'd9:    d = 22'd273;
            4'd10:   d = 22'd304;
            default: d = 22'd334;
        endcase
        return d;
    endfunction

    // quotient by 100 through a reciprocal, exact for 14-bit values
    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = {13'd0, x} * 27'd5243;
        return p[26:19];
    endfunction

endpackage

// ===== rtl/hdep_char_if.sv =====
// character request channel of the http date parser
`timescale 1ns / 1ps
interface hdep_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/hdep_date_if.sv =====
// parsed date result channel of the http date parser
`timescale 1ns / 1ps
interface hdep_date_if;
    logic        valid;
    logic        ready;
    logic        date_valid;
    logic [37:0] epoch_seconds;

    modport source (output valid, output date_valid, output epoch_seconds, input ready);
    modport sink (input valid, input date_valid, input epoch_seconds, output ready);
endinterface

// ===== rtl/hdep_scanner.sv =====
// per-character scanner holding the running parse state
`timescale 1ns / 1ps
`include "http_date_to_epoch_parser_core_macros.svh"
module hdep_scanner
    import hdep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       accept,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output logic       snap_valid,
    output hdep_snap_t snap
);

    hdep_state_t st_reg;
    hdep_state_t st_next;
    logic        ended_reg;
    logic        ended_next;
    logic        snap_valid_reg;
    hdep_snap_t  snap_reg;

    // scan the character unless a zero byte already ended the text
    always_comb
    begin
        if (ended_reg) begin
            st_next = st_reg;
            ended_next = 1'b1;
        end
        else begin
            st_next = feed(st_reg, char_code);
            ended_next = (char_code == ChZero);
        end
    end

    // running state, reset after every final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= reset_state();
            ended_reg <= 1'b0;
        end
        else if (accept) begin
            if (end_of_text) begin
                st_reg <= reset_state();
                ended_reg <= 1'b0;
            end
            else begin
                st_reg <= st_next;
                ended_reg <= ended_next;
            end
        end
    end

    // hand the closing state to the finisher
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (adv)
            snap_valid_reg <= accept && end_of_text;
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_text) begin
            snap_reg.st <= st_next;
            snap_reg.needs_zero <= !ended_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap = snap_reg;

    `HDEP_ASSERT_NEXT(a_reset_after_final, accept && end_of_text, st_reg.phase == PH_WDAY && !ended_reg && !st_reg.failed)
    `HDEP_ASSERT_NEXT(a_hold_after_zero, ended_reg && !(accept && end_of_text), $stable(st_reg) && ended_reg)
    `HDEP_ASSERT_NOW(a_done_not_failed, st_reg.phase == PH_DONE, !st_reg.failed)

endmodule

// ===== rtl/hdep_finish.sv =====
// closes the last open element and decides validity
`timescale 1ns / 1ps
module hdep_finish
    import hdep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         snap_valid,
    input  hdep_snap_t   snap,
    output logic         fields_valid,
    output hdep_fields_t fields
);

    hdep_state_t  st_end;
    hdep_fields_t fields_next;
    logic         fields_valid_reg;
    hdep_fields_t fields_reg;

    // an unterminated text ends as if a zero byte followed
    always_comb
    begin
        st_end = snap.needs_zero ? feed(snap.st, ChZero) : snap.st;
        fields_next.ok = !st_end.failed && st_end.phase == PH_DONE;
        fields_next.yrs = st_end.yrs;
        fields_next.mon = st_end.mon;
        fields_next.mday = st_end.mday;
        fields_next.hour = st_end.hour;
        fields_next.minute = st_end.minute;
        fields_next.sec = st_end.sec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fields_valid_reg <= 1'b0;
        else if (adv)
            fields_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fields_reg <= fields_next;
    end

    assign fields_valid = fields_valid_reg;
    assign fields = fields_reg;

endmodule

// ===== rtl/hdep_epoch.sv =====
// two-stage conversion of parsed fields to seconds since 1970
`timescale 1ns / 1ps
module hdep_epoch
    import hdep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         fields_valid,
    input  hdep_fields_t fields,
    output logic         out_valid,
    output logic         date_valid,
    output logic [37:0]  epoch_seconds
);

    logic [13:0] year;
    logic [13:0] year_m1;
    logic [7:0]  q_year;
    logic [7:0]  q_prev;
    logic [13:0] r_year;
    logic        leap;
    logic [22:0] leap_count;
    logic [22:0] days_next;
    logic [16:0] tod_next;
    logic [3:0]  mon_c;

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic [22:0] days_reg;
    logic [16:0] tod_reg;

    logic [39:0] day_secs;
    logic        out_valid_reg;
    logic        date_valid_reg;
    logic [37:0] epoch_reg;

    // day count: whole years, leap days, months, days
    always_comb
    begin
        year = fields.yrs + 14'd1900;
        year_m1 = year - 14'd1;
        q_year = div100(year);
        q_prev = div100(year_m1);
        r_year = year - {6'd0, q_year} * 14'd100;
        leap = (year[1:0] == 2'd0) && ((r_year != 14'd0) || (q_year[1:0] == 2'd0));
        mon_c = (fields.mon < 4'd12) ? fields.mon : 4'd11;
        leap_count = {11'd0, year_m1[13:2]} - {15'd0, q_prev} + {17'd0, q_prev[7:2]}
            - 23'd477;
        days_next = {9'd0, year - 14'd1970} * 23'd365 + leap_count
            + {1'b0, cum_days(mon_c)} + {22'd0, leap && mon_c > 4'd1}
            + {18'd0, fields.mday} - 23'd1;
        tod_next = {12'd0, fields.hour} * 17'd3600 + {11'd0, fields.minute} * 17'd60
            + {11'd0, fields.sec};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= fields_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_ok_reg <= fields.ok;
            days_reg <= days_next;
            tod_reg <= tod_next;
        end
    end

    // scale days to seconds and add the time of day
    assign day_secs = {17'd0, days_reg} * 40'd86400;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            date_valid_reg <= s1_ok_reg;
            epoch_reg <= s1_ok_reg ? day_secs[37:0] + {21'd0, tod_reg} : 38'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign date_valid = date_valid_reg;
    assign epoch_seconds = epoch_reg;

endmodule

// ===== rtl/http_date_to_epoch_parser_core.sv =====
// Parses an HTTP date text (RFC 1123, RFC 850 or asctime form) fed one
// character per request and, for the request that carries end_of_text,
// returns date_valid and the seconds since 1970-01-01 00:00:00 UTC (zero when
// the text is not a valid date). One character is taken every cycle while no
// result is held; the result for a final character is registered in turn by
// the scanner, the finisher and the two epoch arithmetic register stages.
// The whole pipeline holds while a result waits on a low ready.
`timescale 1ns / 1ps
`include "http_date_to_epoch_parser_core_macros.svh"
module http_date_to_epoch_parser_core
    import hdep_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    hdep_char_if.sink   char_in,
    hdep_date_if.source date_out
);

    logic         adv;
    logic         accept;
    logic         snap_valid;
    hdep_snap_t   snap;
    logic         fields_valid;
    hdep_fields_t fields;
    logic         out_valid;
    logic         date_valid;
    logic [37:0]  epoch_seconds;

    // advance everything unless a result is held
    assign adv = !out_valid || date_out.ready;
    assign char_in.ready = adv;
    assign accept = char_in.valid && adv;

    hdep_scanner u_scanner (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .accept      (accept),
        .char_code   (char_in.char_code),
        .end_of_text (char_in.end_of_text),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    hdep_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .snap_valid   (snap_valid),
        .snap         (snap),
        .fields_valid (fields_valid),
        .fields       (fields)
    );

    hdep_epoch u_epoch (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .fields_valid  (fields_valid),
        .fields        (fields),
        .out_valid     (out_valid),
        .date_valid    (date_valid),
        .epoch_seconds (epoch_seconds)
    );

    assign date_out.valid = out_valid;
    assign date_out.date_valid = date_valid;
    assign date_out.epoch_seconds = epoch_seconds;

    `HDEP_ASSERT_NOW(a_invalid_is_zero, out_valid && !date_valid, epoch_seconds == 38'd0)

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the http date to epoch parser core
`timescale 1ns / 1ps
module tb;
    import hdep_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         hold;
    } char_req_t;

    typedef struct {
        logic        ok;
        logic [37:0] secs;
    } date_result_t;

    logic clk;
    logic rst_n;

    hdep_char_if char_ch ();
    hdep_date_if date_ch ();

    http_date_to_epoch_parser_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch),
        .date_out (date_ch)
    );

    char_req_t    pending_chars[$];
    date_result_t expected_dates[$];
    int           mismatches;
    int           dates_seen;
    int           dates_good;
    int           chars_sent;
    bit           calm;

    // local copy of the parser state
    hdep_phase_t  m_phase;
    bit           m_long;
    bit [25:0]    m_flags;
    int unsigned  m_pos;
    bit           m_in_tok;
    int unsigned  m_num;
    int unsigned  m_mon;
    int unsigned  m_mday;
    int unsigned  m_hour;
    int unsigned  m_min;
    int unsigned  m_sec;
    int unsigned  m_yrs;
    bit           m_failed;
    bit           m_ended;

    string word_list[26] = '{"sun", "mon", "tue", "wed", "thu", "fri", "sat",
        "sunday", "monday", "tuesday", "wednesday", "thursday", "friday", "saturday",
        "jan", "feb", "mar", "apr", "may", "jun", "jul", "aug", "sep", "oct", "nov", "dec"};
    int unsigned days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function automatic void parser_clear();
        m_phase = PH_WDAY;
        m_long = 0;
        m_flags = '1;
        m_pos = 0;
        m_in_tok = 0;
        m_num = 0;
        m_mon = 0;
        m_mday = 0;
        m_hour = 0;
        m_min = 0;
        m_sec = 0;
        m_yrs = 0;
        m_failed = 0;
        m_ended = 0;
    endfunction

    function automatic bit letter(int unsigned c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit(int unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    // narrow the candidate names by one letter
    function automatic void take_letter(int unsigned c);
        int unsigned lc;
        string       zone;
        zone = "gmt";
        lc = (c >= "A" && c <= "Z") ? c + 32 : c;
        if (m_phase == PH_ZONE) begin
            if (m_pos < 3 && zone[m_pos] != lc)
                m_flags[0] = 0;
        end
        else begin
            for (int i = 0; i < 26; i++)
                if (m_pos >= word_list[i].len() || word_list[i][m_pos] != lc)
                    m_flags[i] = 0;
        end
        if (m_pos < 15)
            m_pos++;
    endfunction

    function automatic int whole_word(int lo, int hi);
        for (int i = lo; i < hi; i++)
            if (m_flags[i] && m_pos == word_list[i].len())
                return i;
        return -1;
    endfunction

    function automatic void close_word();
        int m;
        case (m_phase)
            PH_WDAY:
                if (whole_word(0, 14) < 0) m_failed = 1;
                else m_phase = PH_WORD2;
            PH_WORD2:
            begin
                m = whole_word(14, 26);
                m_long = m >= 0;
                if (m >= 0) m_mon = m - 14;
                m_phase = PH_MDAY;
            end
            PH_MONWORD:
            begin
                m = whole_word(14, 26);
                if (m < 0) m_failed = 1;
                else
                begin
                    m_mon = m - 14;
                    m_phase = PH_YEAR;
                end
            end
            default:
                if (m_flags[0] && m_pos >= 3) m_phase = PH_DONE;
                else m_failed = 1;
        endcase
        m_in_tok = 0;
        m_pos = 0;
        m_flags = '1;
    endfunction

    function automatic void close_number();
        int unsigned n;
        n = m_num;
        case (m_phase)
            PH_MDAY:
                if (n < 1 || n > 31) m_failed = 1;
                else
                begin
                    m_mday = n;
                    m_phase = m_long ? PH_HOUR : PH_MONWORD;
                end
            PH_HOUR:
                if (n >= 24) m_failed = 1;
                else
                begin
                    m_hour = n;
                    m_phase = PH_MIN;
                end
            PH_MIN:
                if (n >= 60) m_failed = 1;
                else
                begin
                    m_min = n;
                    m_phase = PH_SEC;
                end
            PH_SEC:
                if (n >= 60) m_failed = 1;
                else
                begin
                    m_sec = n;
                    m_phase = m_long ? PH_YEAR : PH_ZONE;
                end
            default:
                if (n < 70 || (n > 99 && n < 1970)) m_failed = 1;
                else
                begin
                    m_yrs = (n >= 1970) ? n - 1900 : n;
                    m_phase = m_long ? PH_DONE : PH_HOUR;
                end
        endcase
        m_in_tok = 0;
        m_num = 0;
    endfunction

    // one character may close several elements before it is used
    function automatic void scan_char(int unsigned c);
        bit wordy;
        for (int g = 0; g < 16; g++)
        begin
            if (m_failed || m_phase == PH_DONE)
                return;
            wordy = m_phase inside {PH_WDAY, PH_WORD2, PH_MONWORD, PH_ZONE};
            if (wordy)
            begin
                if (letter(c))
                begin
                    if (!m_in_tok)
                    begin
                        m_in_tok = 1;
                        m_pos = 0;
                        m_flags = '1;
                    end
                    take_letter(c);
                    return;
                end
                if (m_in_tok || digit(c) || c == 0)
                    close_word();
                else
                    return;
            end
            else
            begin
                if (digit(c))
                begin
                    if (!m_in_tok)
                    begin
                        m_in_tok = 1;
                        m_num = 0;
                    end
                    m_num = m_num * 10 + (c - "0");
                    if (m_num > 9999) m_num = 9999;
                    return;
                end
                if (m_in_tok)
                    close_number();
                else
                begin
                    if (c == 0) m_failed = 1;
                    return;
                end
            end
        end
    endfunction

    function automatic longint unsigned leap_count(longint unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic logic [37:0] epoch_of_fields();
        longint unsigned y;
        longint unsigned days;
        int unsigned     mon;
        bit              leap;
        y = m_yrs + 1900;
        mon = m_mon < 12 ? m_mon : 11;
        days = 365 * (y - 1970) + leap_count(y - 1) - leap_count(1969);
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        days += days_before[mon];
        if (leap && mon > 1) days++;
        days += m_mday - 1;
        return 38'(days * 86400 + m_hour * 3600 + m_min * 60 + m_sec);
    endfunction

    // advance the local parser by one accepted character
    function automatic void predict_char(logic [7:0] c, logic eot);
        date_result_t r;
        bit ok;
        if (!m_ended)
        begin
            scan_char(c);
            if (c == 0) m_ended = 1;
        end
        if (eot)
        begin
            if (!m_ended) scan_char(0);
            ok = !m_failed && m_phase == PH_DONE;
            r.ok = ok;
            r.secs = ok ? epoch_of_fields() : '0;
            expected_dates.push_back(r);
            parser_clear();
        end
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // queue a text; mutate: 0 none, 1 random byte, 2 truncate, 3 zero byte, 4 trailing junk
    task automatic queue_text(string s, int mutate, bit hold);
        logic [7:0] b[$];
        int         k;
        char_req_t  q;
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
        if (b.size() == 0) b.push_back(8'h20);
        k = $urandom_range(0, b.size() - 1);
        case (mutate)
            1: b[k] = 8'($urandom_range(0, 255));
            2: while (b.size() > k + 1) void'(b.pop_back());
            3: b[k] = 8'h00;
            4: repeat ($urandom_range(1, 6)) b.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
        foreach (b[i])
        begin
            q.ch = b[i];
            q.eot = (i == b.size() - 1);
            q.hold = hold && (i == 0);
            pending_chars.push_back(q);
        end
    endtask

    function automatic string mix_case(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if ($urandom_range(0, 1) && t[i] >= "a" && t[i] <= "z")
                t[i] = t[i] - 32;
        return t;
    endfunction

    function automatic string random_date();
        int    form;
        int    day;
        int    yr;
        int    hh;
        int    mi;
        int    ss;
        bit    wild;
        string wd;
        string mo;
        string zone;
        form = $urandom_range(0, 2);
        wild = $urandom_range(0, 5) == 0;
        wd = mix_case(word_list[$urandom_range(0, 13)]);
        mo = mix_case(word_list[$urandom_range(14, 25)]);
        day = wild ? $urandom_range(0, 40) : $urandom_range(1, 31);
        hh = wild ? $urandom_range(0, 30) : $urandom_range(0, 23);
        mi = wild ? $urandom_range(0, 70) : $urandom_range(0, 59);
        ss = wild ? $urandom_range(0, 70) : $urandom_range(0, 59);
        yr = wild ? $urandom_range(0, 2100) :
            ($urandom_range(0, 3) == 0 ? $urandom_range(1970, 9999) : $urandom_range(1970, 2040));
        zone = mix_case($urandom_range(0, 7) == 0 ? "gmx" : "gmt");
        case (form)
            0: return $sformatf("%s, %02d %s %04d %02d:%02d:%02d %s",
                wd, day, mo, yr, hh, mi, ss, zone);
            1: return $sformatf("%s, %02d-%s-%02d %02d:%02d:%02d %s", wd, day, mo,
                wild ? yr % 100 : $urandom_range(70, 99), hh, mi, ss, zone);
            default: return $sformatf("%s %s %2d %02d:%02d:%02d %04d",
                wd, mo, day, hh, mi, ss, yr);
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // sender of character requests
    int        send_gap;
    char_req_t head;
    always @(posedge clk or negedge rst_n)
    begin
        bit busy;
        if (!rst_n)
        begin
            char_ch.valid <= 0;
            char_ch.char_code <= '0;
            char_ch.end_of_text <= 0;
            send_gap = 0;
        end
        else
        begin
            busy = char_ch.valid;
            if (char_ch.valid && char_ch.ready)
            begin
                predict_char(char_ch.char_code, char_ch.end_of_text);
                chars_sent++;
                if (chars_sent % 250 == 0) calm = ~calm;
                busy = 0;
                send_gap = draw_wait();
            end
            if (!busy)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_chars.size() > 0 &&
                    (!pending_chars[0].hold || expected_dates.size() == 0))
                begin
                    head = pending_chars.pop_front();
                    char_ch.char_code <= head.ch;
                    char_ch.end_of_text <= head.eot;
                    busy = 1;
                end
            end
            char_ch.valid <= busy;
        end
    end

    // receiver of date results
    int take_gap;
    always @(posedge clk or negedge rst_n)
    begin
        date_result_t want;
        if (!rst_n)
        begin
            date_ch.ready <= 0;
            take_gap = 0;
        end
        else
        begin
            if (date_ch.valid && date_ch.ready)
            begin
                dates_seen++;
                if (expected_dates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected date result: valid %0b secs %0d",
                            date_ch.date_valid, date_ch.epoch_seconds);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (want.ok) dates_good++;
                    if (date_ch.date_valid !== want.ok || date_ch.epoch_seconds !== want.secs)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"date mismatch: expected valid %0b secs %0d, ",
                                "got valid %0b secs %0d"},
                                want.ok, want.secs, date_ch.date_valid, date_ch.epoch_seconds);
                    end
                end
                take_gap = draw_wait();
            end
            else if (take_gap > 0)
                take_gap--;
            date_ch.ready <= (take_gap == 0);
        end
    end

    // stimulus and end of run
    initial
    begin
        string junk;
        mismatches = 0;
        dates_seen = 0;
        dates_good = 0;
        chars_sent = 0;
        calm = 0;
        parser_clear();
        rst_n = 0;

        // directed texts
        queue_text("Sun, 06 Nov 1994 08:49:37 GMT", 0, 0);
        queue_text("Wednesday, 30-Sep-70 23:59:59 gmtfoo", 0, 0);
        queue_text("THU Jan  1 00:00:00 1970", 0, 0);
        queue_text("Sat, 31 Dec 9999 23:59:59 GMT", 0, 1);
        queue_text("Mon, 31 Feb 2000 12:00:00 GMT", 0, 0);
        queue_text("Tue, 01 Mar 99999 00:00:00 GMT", 0, 0);
        queue_text("Fri, 01 Jan 1969 00:00:00 GMT", 0, 0);
        queue_text("Fri, 01 Jan 69 00:00:00 GMT", 0, 0);
        queue_text("Fri, 01 Jan 100 00:00:00 GMT", 0, 0);
        queue_text("Sun, 00 Jan 1980 24:60:60 GMT", 0, 0);
        queue_text("Saturdayy, 01 Jan 1980 00:00:00 GMT", 0, 0);
        queue_text("Sunday, 01 Jan 1980 00:00:00 GM", 0, 0);
        queue_text("Sun, 01 Xyz 1980 00:00:00 GMT", 0, 0);
        queue_text("Monabcdefghijklmnopq 01", 0, 0);
        queue_text("Sun Feb 29 1:2:3 2000", 0, 0);
        queue_text("Sun", 0, 0);
        queue_text("", 0, 0);
        junk = {"Tue", string'(8'hff), string'(8'h80), "Aug", string'(8'hc3),
            " 15 13:45:01 2024"};
        queue_text(junk, 0, 0);
        queue_text("Sun, 06 Nov 1994 08:49:37 GMT", 3, 0);
        queue_text("Sun Nov 6 08:49:37 1994 trailing", 0, 0);

        // random texts, mostly well-formed with random content
        for (int n = 0; pending_chars.size() < 600; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                junk = "";
                repeat ($urandom_range(1, 12)) junk = {junk, string'(8'($urandom_range(1, 255)))};
                queue_text(junk, $urandom_range(0, 1) ? 3 : 0, n == 45);
            end
            else
                queue_text(random_date(), $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0,
                    n == 45);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1;

        wait (pending_chars.size() == 0 && !char_ch.valid);
        wait (expected_dates.size() == 0);
        repeat (20) @(posedge clk);

        $display("covered %0d characters and %0d dates, %0d of them valid, in all three forms",
            chars_sent, dates_seen, dates_good);
        $display("mismatches counted: %0d", mismatches);
        if (mismatches == 0 && expected_dates.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

endmodule
